FILE: sv/assert_macros.svh
// Assertion macros used by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, skipped while arst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clk edge.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: sv/klex_pkg.sv
// Types, constants and helper functions of the keyword lexer.
`default_nettype none
package klex_pkg;

	localparam int MAX_WORD    = 32;
	localparam int POS_W       = 16;
	localparam int CHUNK_BYTES = 8;
	localparam int CHUNK_W     = CHUNK_BYTES * 8;
	localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
	localparam int NCHUNK      = MAX_WORD / CHUNK_BYTES;
	localparam int CIDX_W      = $clog2(NCHUNK);
	localparam int LEN_W       = $clog2(MAX_WORD + 1);
	localparam int IDX_W       = $clog2(MAX_WORD);
	localparam int TEXT_W      = MAX_WORD * 8;
	localparam int KW_BYTES    = 5;
	localparam int KW_W        = KW_BYTES * 8;

	typedef logic [POS_W-1:0] pos_t;
	localparam pos_t POS_MAX = '1;

	typedef enum logic [3:0] {
		KIND_INT   = 4'd0,
		KIND_EXIT  = 4'd1,
		KIND_LET   = 4'd2,
		KIND_CONST = 4'd3,
		KIND_PRINT = 4'd4,
		KIND_IDENT = 4'd5,
		KIND_LPAR  = 4'd6,
		KIND_RPAR  = 4'd7,
		KIND_EQ    = 4'd8,
		KIND_SEMI  = 4'd9,
		KIND_BAD   = 4'd10,
		KIND_LONG  = 4'd11
	} kind_t;

	// Source bytes with special meaning.
	localparam logic [7:0] CH_LPAR    = 8'h28;
	localparam logic [7:0] CH_RPAR    = 8'h29;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;

	// Keyword text, first character in the low byte, zero padded.
	localparam logic [KW_W-1:0] KW_EXIT  = 40'h00_7469_7865;
	localparam logic [KW_W-1:0] KW_LET   = 40'h00_0074_656C;
	localparam logic [KW_W-1:0] KW_CONST = 40'h74_736E_6F63;
	localparam logic [KW_W-1:0] KW_PRINT = 40'h74_6E69_7270;

	// One result descriptor: an optional word run, then an optional single beat.
	typedef struct packed {
		logic                word_pend;
		logic                single_pend;
		pos_t                line;
		kind_t               w_kind;
		logic [LEN_W-1:0]    w_len;
		pos_t                w_col;
		logic [TEXT_W-1:0]   w_text;
		logic [CIDX_W-1:0]   w_last_idx;
		kind_t               s_kind;
		pos_t                s_col;
		logic                s_len;
		logic [7:0]          s_text;
	} desc_t;

	function automatic pos_t sat_inc(input pos_t v);
		return (v == POS_MAX) ? v : v + pos_t'(1);
	endfunction

	// Text must be zero past the word length.
	function automatic kind_t kw_kind(input logic [KW_W-1:0] txt, input logic [LEN_W-1:0] len);
		kind_t k;
		k = KIND_IDENT;
		if (len == LEN_W'(4) && txt == KW_EXIT) k = KIND_EXIT;
		else if (len == LEN_W'(3) && txt == KW_LET) k = KIND_LET;
		else if (len == LEN_W'(5) && txt == KW_CONST) k = KIND_CONST;
		else if (len == LEN_W'(5) && txt == KW_PRINT) k = KIND_PRINT;
		return k;
	endfunction

endpackage
`default_nettype wire

FILE: sv/klex_emit.sv
// Result register and beat sequencer: word chunks, then the single token.
`default_nettype none
module klex_emit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire klex_pkg::desc_t               desc,
	output logic                               free,
	output logic                               tok_valid,
	input  wire logic                          tok_ready,
	output logic [3:0]                         kind,
	output logic [klex_pkg::POS_W-1:0]         line,
	output logic [klex_pkg::POS_W-1:0]         column,
	output logic [klex_pkg::LEN_W-1:0]         length,
	output logic [klex_pkg::CHUNK_W-1:0]       text_chunk,
	output logic [klex_pkg::CIDX_W-1:0]        chunk_index,
	output logic                               last_of_run
);
	import klex_pkg::*;

	desc_t             d_s1;
	logic              wpend_s1;
	logic              spend_s1;
	logic [CIDX_W-1:0] cnt_q;
	logic              word_end;
	logic              final_beat;
	logic              beat;

	assign word_end   = (cnt_q == d_s1.w_last_idx);
	assign final_beat = wpend_s1 ? (word_end && !spend_s1) : spend_s1;
	assign tok_valid  = wpend_s1 || spend_s1;
	assign beat       = tok_valid && tok_ready;
	assign free       = !tok_valid || (tok_ready && final_beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpend_s1 <= 1'b0;
			spend_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (load) begin
			wpend_s1 <= desc.word_pend;
			spend_s1 <= desc.single_pend;
			cnt_q    <= '0;
		end else if (beat) begin
			if (wpend_s1) begin
				if (word_end) begin
					wpend_s1 <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CIDX_W'(1);
				end
			end else begin
				spend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			d_s1 <= desc;
		end
	end

	always_comb begin
		line = d_s1.line;
		if (wpend_s1) begin
			kind        = d_s1.w_kind;
			column      = d_s1.w_col;
			length      = d_s1.w_len;
			text_chunk  = d_s1.w_text[cnt_q*CHUNK_W +: CHUNK_W];
			chunk_index = cnt_q;
			last_of_run = word_end;
		end else begin
			kind        = d_s1.s_kind;
			column      = d_s1.s_col;
			length      = LEN_W'(d_s1.s_len);
			text_chunk  = CHUNK_W'(d_s1.s_text);
			chunk_index = '0;
			last_of_run = 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: sv/keyword_lexer_with_positions.sv
// Top level of the streaming keyword lexer with line and column tracking.
// Latency: the first result beat of a byte is offered the cycle after the byte's beat.
// Throughput: one byte per cycle while each byte yields at most one result beat and tok_ready is high;
//   a byte yielding more beats (up to five) holds src_ready low until its final beat is taken.
// Reset: arst_n clears scan mode, word length and positions (line 1, column 1).
//   The word byte store has no reset; only bytes already written are ever shown.
`default_nettype none
`include "assert_macros.svh"
module keyword_lexer_with_positions (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          src_valid,
	output logic                               src_ready,
	input  wire logic [7:0]                    ch,
	input  wire logic                          last_byte,
	output logic                               tok_valid,
	input  wire logic                          tok_ready,
	output logic [3:0]                         kind,
	output logic [klex_pkg::POS_W-1:0]         line,
	output logic [klex_pkg::POS_W-1:0]         column,
	output logic [klex_pkg::LEN_W-1:0]         length,
	output logic [klex_pkg::CHUNK_W-1:0]       text_chunk,
	output logic [klex_pkg::CIDX_W-1:0]        chunk_index,
	output logic                               last_of_run
);
	import klex_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_LETTERS = 2'd1,
		MODE_DIGITS  = 2'd2,
		MODE_HALT    = 2'd3
	} mode_t;

	// Scanner state, updated on every accepted source beat.
	mode_t            mode_q, mode_n;
	logic [7:0]       word_q [MAX_WORD];
	logic [7:0]       store_n [MAX_WORD];
	logic [LEN_W-1:0] len_q, len_n;
	pos_t             start_q, start_n;
	pos_t             line_q, line_n;
	pos_t             col_q, col_n;

	mode_t            cls;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic             accept;

	// Word run to flush: either the old word (before this byte) or the new one.
	logic             a_pend;
	logic             a_old;
	mode_t            a_mode;
	logic [LEN_W-1:0] a_len;
	pos_t             a_col;
	logic [TEXT_W-1:0] a_text;
	kind_t            a_kw;
	kind_t            a_kind;
	logic [LEN_W-1:0] a_len_m1;

	// Single-beat token behind the word run.
	logic             s_pend;
	kind_t            s_kind;
	pos_t             s_col;
	logic             s_len;
	logic [7:0]       s_text;

	desc_t            desc;
	logic             load;

	assign accept = src_valid && src_ready;

	// Classify the incoming byte.
	always_comb begin
		if (ch inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDER}) begin
			cls = MODE_LETTERS;
		end else if (ch inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
			cls = MODE_DIGITS;
		end else begin
			cls = MODE_IDLE;
		end
	end

	// Next-state and result selection for one byte.
	always_comb begin
		mode_n  = mode_q;
		len_n   = len_q;
		start_n = start_q;
		line_n  = line_q;
		col_n   = col_q;
		wr_en   = 1'b0;
		wr_idx  = len_q[IDX_W-1:0];
		a_pend  = 1'b0;
		a_old   = 1'b1;
		a_mode  = mode_q;
		a_len   = len_q;
		a_col   = start_q;
		s_pend  = 1'b0;
		s_kind  = KIND_BAD;
		s_col   = col_q;
		s_len   = 1'b0;
		s_text  = '0;

		if (mode_q == MODE_HALT) begin
			// drop everything until reset
		end else if (mode_q != MODE_IDLE && cls == mode_q) begin
			if (len_q >= LEN_W'(MAX_WORD)) begin
				// word overflow: report at the word start and halt, no flush
				s_pend = 1'b1;
				s_kind = KIND_LONG;
				s_col  = start_q;
				mode_n = MODE_HALT;
			end else begin
				wr_en  = 1'b1;
				wr_idx = len_q[IDX_W-1:0];
				len_n  = len_q + LEN_W'(1);
				col_n  = sat_inc(col_q);
			end
		end else begin
			if (mode_q != MODE_IDLE) begin
				a_pend = 1'b1;
				mode_n = MODE_IDLE;
				len_n  = '0;
			end
			case (cls)
				MODE_LETTERS, MODE_DIGITS: begin
					start_n = col_q;
					wr_en   = 1'b1;
					wr_idx  = '0;
					len_n   = LEN_W'(1);
					col_n   = sat_inc(col_q);
					mode_n  = cls;
				end
				default: begin
					case (ch)
						CH_LPAR: begin
							s_pend = 1'b1;
							s_kind = KIND_LPAR;
							col_n  = sat_inc(col_q);
						end
						CH_RPAR: begin
							s_pend = 1'b1;
							s_kind = KIND_RPAR;
							col_n  = sat_inc(col_q);
						end
						CH_EQ: begin
							s_pend = 1'b1;
							s_kind = KIND_EQ;
							col_n  = sat_inc(col_q);
						end
						CH_SEMI: begin
							s_pend = 1'b1;
							s_kind = KIND_SEMI;
							col_n  = sat_inc(col_q);
						end
						CH_SPACE: begin
							col_n = sat_inc(col_q);
						end
						CH_NL: begin
							line_n = sat_inc(line_q);
							col_n  = pos_t'(1);
						end
						default: begin
							s_pend = 1'b1;
							s_kind = KIND_BAD;
							s_text = ch;
							mode_n = MODE_HALT;
						end
					endcase
				end
			endcase
		end

		// Last byte closes the open word after this byte is taken.
		if (last_byte && (mode_n == MODE_LETTERS || mode_n == MODE_DIGITS)) begin
			if (a_pend) begin
				// old word goes first; the fresh one-character word follows
				s_pend = 1'b1;
				s_kind = (cls == MODE_DIGITS) ? KIND_INT : KIND_IDENT;
				s_col  = col_q;
				s_len  = 1'b1;
				s_text = ch;
			end else begin
				a_pend = 1'b1;
				a_old  = 1'b0;
				a_mode = mode_n;
				a_len  = len_n;
				a_col  = start_n;
			end
			mode_n = MODE_IDLE;
			len_n  = '0;
		end
	end

	// Store contents with this byte written, and the masked text snapshot.
	for (genvar i = 0; i < MAX_WORD; i++) begin : g_text
		assign store_n[i] = (wr_en && wr_idx == IDX_W'(i)) ? ch : word_q[i];
		assign a_text[i*8 +: 8] = (LEN_W'(i) < a_len) ?
			(a_old ? word_q[i] : store_n[i]) : 8'h00;
	end

	assign a_kw     = kw_kind(a_text[KW_W-1:0], a_len);
	assign a_kind   = (a_mode == MODE_DIGITS) ? KIND_INT : a_kw;
	assign a_len_m1 = a_len - LEN_W'(1);

	always_comb begin
		desc.word_pend   = a_pend;
		desc.single_pend = s_pend;
		desc.line        = line_q;
		desc.w_kind      = a_kind;
		desc.w_len       = a_len;
		desc.w_col       = a_col;
		desc.w_text      = a_text;
		// keywords go out as one chunk; other words as ceil(length/8) chunks
		desc.w_last_idx  = (a_kind == KIND_INT || a_kind == KIND_IDENT) ?
			CIDX_W'(a_len_m1 >> CHUNK_SHIFT) : '0;
		desc.s_kind      = s_kind;
		desc.s_col       = s_col;
		desc.s_len       = s_len;
		desc.s_text      = s_text;
	end

	assign load = accept && (a_pend || s_pend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			len_q   <= '0;
			start_q <= pos_t'(1);
			line_q  <= pos_t'(1);
			col_q   <= pos_t'(1);
		end else if (accept) begin
			mode_q  <= mode_n;
			len_q   <= len_n;
			start_q <= start_n;
			line_q  <= line_n;
			col_q   <= col_n;
		end
	end

	// Word byte store: one write port, no reset.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			word_q[wr_idx] <= ch;
		end
	end

	// Result register and beat sequencing; src_ready follows its free slot.
	klex_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.desc        (desc),
		.free        (src_ready),
		.tok_valid   (tok_valid),
		.tok_ready   (tok_ready),
		.kind        (kind),
		.line        (line),
		.column      (column),
		.length      (length),
		.text_chunk  (text_chunk),
		.chunk_index (chunk_index),
		.last_of_run (last_of_run)
	);

	// A new byte is taken over a pending result only as that token's last beat leaves.
	`ASSERT_CLK(a_ready_on_final, src_ready && tok_valid |-> tok_ready && last_of_run, "src_ready while result beats remain")
	// Halt holds until reset.
	`ASSERT_CLK(a_halt_sticky, mode_q == MODE_HALT |=> mode_q == MODE_HALT, "left halt without reset")
	// No word text is held outside a word.
	`ASSERT_NEVER(a_idle_empty, mode_q == MODE_IDLE && len_q != '0, "word length nonzero while idle")
	// Word length stays within the store.
	`ASSERT_NEVER(a_len_bound, len_q > LEN_W'(MAX_WORD), "word length beyond store depth")

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the streaming keyword lexer with line and column positions.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import klex_pkg::*;

	// Cycle limit, set with plenty of margin over a correct run even with every gap and
	// stall at its longest.
	localparam int CYCLE_LIMIT = 200_000;
	// Cycles the sink holds tok_ready low in the pressure test.
	localparam int LONG_HOLD   = 300;
	// Cycles to wait after the last expected beat; the block answers the cycle after a byte.
	localparam int DRAIN_WAIT  = 20;
	localparam int RANDOM_ITEMS   = 25;
	localparam int PRESSURE_ITEMS = 20;

	// Scanner state as the predictor tracks it.
	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_LETTERS,
		SCAN_DIGITS,
		SCAN_HALTED
	} scan_t;

	// One token beat as it should leave the block.
	typedef struct {
		kind_t                kind;
		pos_t                 line;
		pos_t                 column;
		logic [LEN_W-1:0]     length;
		logic [CHUNK_W-1:0]   chunk;
		logic [CIDX_W-1:0]    index;
		logic                 is_last;
	} token_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 src_valid = 1'b0;
	logic                 src_ready;
	logic [7:0]           ch = '0;
	logic                 last_byte = 1'b0;
	logic                 tok_valid;
	logic                 tok_ready = 1'b0;
	logic [3:0]           kind;
	logic [POS_W-1:0]     line;
	logic [POS_W-1:0]     column;
	logic [LEN_W-1:0]     length;
	logic [CHUNK_W-1:0]   text_chunk;
	logic [CIDX_W-1:0]    chunk_index;
	logic                 last_of_run;

	// Predictor state.
	scan_t        scan_state;
	logic [7:0]   word_buf [MAX_WORD];
	int           word_len;
	pos_t         word_col;
	pos_t         cur_line;
	pos_t         cur_col;

	token_beat_t  expected_beats[$];
	int           mismatches = 0;
	int           items_sent = 0;
	longint       cycle_count = 0;

	// Idling controls. The sink process owns the hold and stall counters.
	bit           sender_gaps = 1'b1;
	bit           sink_stalls = 1'b1;
	bit           hold_request = 1'b0;
	int           hold_left = 0;
	int           stall_left = 0;

	string        keywords[4] = '{"exit", "let", "const", "print"};

	keyword_lexer_with_positions DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.ch          (ch),
		.last_byte   (last_byte),
		.tok_valid   (tok_valid),
		.tok_ready   (tok_ready),
		.kind        (kind),
		.line        (line),
		.column      (column),
		.length      (length),
		.text_chunk  (text_chunk),
		.chunk_index (chunk_index),
		.last_of_run (last_of_run)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d beats outstanding", $time,
				expected_beats.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------------------

	// Positions stick at the top value instead of wrapping.
	function automatic pos_t sat_next(pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	// Word class of a source byte; IDLE means the byte is not part of a word.
	function automatic scan_t class_of(logic [7:0] c);
		if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
			c == CH_UNDER)
			return SCAN_LETTERS;
		if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
			return SCAN_DIGITS;
		return SCAN_IDLE;
	endfunction

	function automatic bit word_is(string s);
		if (word_len != s.len())
			return 1'b0;
		for (int i = 0; i < word_len; i++)
			if (word_buf[i] != s[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Eight bytes of the pending word, first byte low, zero past the end of the word.
	function automatic logic [CHUNK_W-1:0] word_chunk(int c);
		logic [CHUNK_W-1:0] v;
		int p;
		v = '0;
		for (int i = 0; i < CHUNK_BYTES; i++) begin
			p = c * CHUNK_BYTES + i;
			if (p < word_len)
				v[8*i +: 8] = word_buf[p];
		end
		return v;
	endfunction

	task automatic push_beat(kind_t k, pos_t col, int len, logic [CHUNK_W-1:0] chunk,
		int idx, bit lst);
		token_beat_t b;
		b.kind    = k;
		b.line    = cur_line;
		b.column  = col;
		b.length  = LEN_W'(len);
		b.chunk   = chunk;
		b.index   = CIDX_W'(idx);
		b.is_last = lst;
		expected_beats.insert(expected_beats.size(), b);
	endtask

	// Emit the pending word: keywords go out as one beat, other words one beat per chunk.
	task automatic flush_pending_word();
		kind_t k;
		int nchunks;
		k = KIND_IDENT;
		if (scan_state == SCAN_DIGITS)
			k = KIND_INT;
		else if (word_is("exit"))
			k = KIND_EXIT;
		else if (word_is("let"))
			k = KIND_LET;
		else if (word_is("const"))
			k = KIND_CONST;
		else if (word_is("print"))
			k = KIND_PRINT;
		if (k != KIND_INT && k != KIND_IDENT) begin
			push_beat(k, word_col, word_len, word_chunk(0), 0, 1'b1);
		end else begin
			nchunks = (word_len + CHUNK_BYTES - 1) / CHUNK_BYTES;
			for (int i = 0; i < nchunks; i++)
				push_beat(k, word_col, word_len, word_chunk(i), i, i == nchunks - 1);
		end
		scan_state = SCAN_IDLE;
		word_len = 0;
	endtask

	task automatic predict_reset();
		scan_state = SCAN_IDLE;
		word_len = 0;
		word_col = pos_t'(1);
		cur_line = pos_t'(1);
		cur_col = pos_t'(1);
	endtask

	// Work out the beats that one accepted source byte causes.
	task automatic predict_byte(logic [7:0] c, bit lst);
		scan_t cls;
		kind_t k;
		bit single;
		if (scan_state == SCAN_HALTED)
			return;
		cls = class_of(c);
		single = 1'b1;
		k = KIND_LPAR;
		if (scan_state != SCAN_IDLE && cls == scan_state) begin
			// A word character with the store full: report at the word start and halt.
			if (word_len >= MAX_WORD) begin
				push_beat(KIND_LONG, word_col, 0, '0, 0, 1'b1);
				scan_state = SCAN_HALTED;
				return;
			end
			word_buf[word_len] = c;
			word_len++;
			cur_col = sat_next(cur_col);
		end else begin
			if (scan_state != SCAN_IDLE)
				flush_pending_word();
			if (cls != SCAN_IDLE) begin
				word_col = cur_col;
				word_buf[0] = c;
				word_len = 1;
				cur_col = sat_next(cur_col);
				scan_state = cls;
			end else begin
				case (c)
					CH_LPAR: k = KIND_LPAR;
					CH_RPAR: k = KIND_RPAR;
					CH_EQ:   k = KIND_EQ;
					CH_SEMI: k = KIND_SEMI;
					CH_SPACE: begin
						single = 1'b0;
						cur_col = sat_next(cur_col);
					end
					CH_NL: begin
						single = 1'b0;
						cur_line = sat_next(cur_line);
						cur_col = pos_t'(1);
					end
					default: begin
						push_beat(KIND_BAD, cur_col, 0, CHUNK_W'(c), 0, 1'b1);
						scan_state = SCAN_HALTED;
						return;
					end
				endcase
				if (single) begin
					push_beat(k, cur_col, 0, '0, 0, 1'b1);
					cur_col = sat_next(cur_col);
				end
			end
		end
		if (lst && scan_state != SCAN_IDLE)
			flush_pending_word();
	endtask

	// ---------------------------------------------------------------------------------
	// Source side
	// ---------------------------------------------------------------------------------

	// Offer one byte and hold it until the block takes it. Inputs change on the falling
	// edge; the handshake is sampled on the rising edge. Valid stays high on return so
	// back-to-back bytes need no dead cycle.
	task automatic send_byte(logic [7:0] c, bit lst);
		int gap;
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		ch <= c;
		last_byte <= lst;
		do @(posedge clk); while (!src_ready);
		predict_byte(c, lst);
		items_sent++;
	endtask

	task automatic send_text(string s, bit last_on_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last_on_end && i == s.len() - 1);
	endtask

	function automatic logic [7:0] random_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return CH_UPPER_A + 8'(r);
		if (r < 52)
			return CH_LOWER_A + 8'(r - 26);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] random_digit();
		return CH_DIGIT_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic bit random_last();
		return $urandom_range(0, 9) == 0;
	endfunction

	// Send word text. If it would merge with a pending word of the same class past the
	// store size, put a space in front; overlong words are saved for the halt test.
	task automatic send_word_text(string s, scan_t cls);
		if (scan_state == cls && word_len + s.len() > MAX_WORD)
			send_byte(CH_SPACE, 1'b0);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], random_last());
	endtask

	// One random token of well-formed source, with last marks sprinkled in.
	task automatic send_random_token();
		string s;
		int len;
		logic [7:0] punct [4];
		punct = '{CH_LPAR, CH_RPAR, CH_EQ, CH_SEMI};
		s = "";
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, MAX_WORD) : $urandom_range(1, 8);
		case ($urandom_range(0, 9))
			0, 1: begin
				// Keywords and near misses: extra letter, dropped letter.
				s = keywords[$urandom_range(0, 3)];
				case ($urandom_range(0, 3))
					2: s = $sformatf("%s%c", s, random_letter());
					3: s = s.substr(0, s.len() - 2);
					default: ;
				endcase
				send_word_text(s, SCAN_LETTERS);
			end
			2, 3: begin
				for (int i = 0; i < len; i++)
					s = $sformatf("%s%c", s, random_letter());
				send_word_text(s, SCAN_LETTERS);
			end
			4: begin
				for (int i = 0; i < len; i++)
					s = $sformatf("%s%c", s, random_digit());
				send_word_text(s, SCAN_DIGITS);
			end
			5, 6, 9: send_byte(punct[$urandom_range(0, 3)], random_last());
			7: repeat ($urandom_range(1, 2)) send_byte(CH_SPACE, random_last());
			default: send_byte(CH_NL, random_last());
		endcase
	endtask

	// ---------------------------------------------------------------------------------
	// Sink side
	// ---------------------------------------------------------------------------------

	// Drive tok_ready: a long hold when the pressure test asks, otherwise short random
	// stall bursts while they are enabled.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			tok_ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			tok_ready <= 1'b0;
			stall_left--;
		end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
			tok_ready <= 1'b0;
			stall_left = $urandom_range(0, 11);
		end else begin
			tok_ready <= 1'b1;
		end
	end

	task automatic check_field(string name, logic [CHUNK_W-1:0] want, logic [CHUNK_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// Compare every accepted token beat with the oldest expected one.
	always @(posedge clk) begin
		token_beat_t want;
		if (arst_n && tok_valid && tok_ready) begin
			if (expected_beats.size() == 0) begin
				mismatches++;
				$display("%0t: beat with none expected: kind %0d line %0d column %0d chunk %0h",
					$time, kind, line, column, text_chunk);
			end else begin
				want = expected_beats.pop_front();
				check_field("kind", want.kind, kind);
				check_field("line", want.line, line);
				check_field("column", want.column, column);
				check_field("length", want.length, length);
				check_field("text_chunk", want.chunk, text_chunk);
				check_field("chunk_index", want.index, chunk_index);
				check_field("last_of_run", want.is_last, last_of_run);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------

	// All four keywords, all punctuation, space and newline in one line.
	task automatic test_tokens();
		send_text("exit let(const)=print;\n", 1'b0);
	endtask

	// Letters against digits end each other; the last mark flushes the final word.
	task automatic test_class_change();
		send_text("_Az09Za9", 1'b1);
	endtask

	// Full-size words: a 32-letter identifier closed by '(' gives five beats from one
	// byte, and a 32-digit integer is flushed by the last mark.
	task automatic test_longest_words();
		string s;
		s = "";
		for (int i = 0; i < MAX_WORD; i++)
			s = $sformatf("%s%c", s, random_letter());
		send_text(s, 1'b0);
		send_byte(CH_LPAR, 1'b0);
		s = "";
		for (int i = 0; i < MAX_WORD; i++)
			s = $sformatf("%s%c", s, random_digit());
		send_text(s, 1'b1);
		send_byte(CH_RPAR, 1'b0);
	endtask

	task automatic test_random_source();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS)
			send_random_token();
	endtask

	// Hold the sink off for a long stretch while bytes keep coming, so the block fills
	// and drops src_ready.
	task automatic test_output_pressure();
		int start;
		start = items_sent;
		sender_gaps = 1'b0;
		hold_request = 1'b1;
		while (items_sent - start < PRESSURE_ITEMS)
			send_random_token();
		sender_gaps = 1'b1;
	endtask

	// Words, punctuation and a last-flushed integer with both sides always ready. No
	// idling from here to the end of the run.
	task automatic test_back_to_back();
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		send_text("x abcdefgh()", 1'b0);
		send_text(" 12", 1'b1);
	endtask

	// Trigger one halting error, either a bad byte after a pending word or an overlong
	// word, then feed noise that must produce nothing.
	task automatic test_halt_on_error();
		logic [7:0] c;
		if ($urandom_range(0, 1)) begin
			if ($urandom_range(0, 1)) begin
				c = 8'($urandom_range(128, 255));
			end else begin
				do c = 8'($urandom_range(0, 127));
				while (class_of(c) != SCAN_IDLE || c == CH_LPAR || c == CH_RPAR ||
					c == CH_EQ || c == CH_SEMI || c == CH_SPACE || c == CH_NL);
			end
			send_text("ab", 1'b0);
			send_byte(c, 1'b0);
		end else begin
			for (int i = 0; i <= MAX_WORD; i++)
				send_byte(random_letter(), 1'b0);
		end
		repeat (12) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		predict_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_tokens();
		test_class_change();
		test_longest_words();
		test_random_source();
		test_output_pressure();
		test_back_to_back();
		test_halt_on_error();

		@(negedge clk);
		src_valid <= 1'b0;
		// Drain, then give the block time to show any stray beat.
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/klex_pkg.sv
sv/klex_emit.sv
sv/keyword_lexer_with_positions.sv
verif/testbench.sv
